[src/multi_mode_rotary_input_decoder_assert.svh]
// ----------------------------------------------------------------------------
// multi_mode_rotary_input_decoder_assert.svh
// Assertion macros used by the rotary decoder merge module
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_ROTARY_INPUT_DECODER_ASSERT_SVH
`define MULTI_MODE_ROTARY_INPUT_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define RMID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rmid assertion failed");
// same, with a caller supplied message
`define RMID_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define RMID_ASSERT(lbl, prop)
`define RMID_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

[src/rmid_pkg.sv]
// ----------------------------------------------------------------------------
// rmid_pkg
// Types, register indexes and decode constants of the rotary input decoder
// ----------------------------------------------------------------------------
package rmid_pkg;

  // field widths
  localparam int unsigned PIN_W   = 4;
  localparam int unsigned CH_W    = 2;
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned IDX_W   = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ENABLE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_MODES   = 2'd1;
  localparam logic [IDX_W-1:0] REG_TIMEOUT = 2'd2;

  localparam logic [SPEED_W-1:0] TIMEOUT_RESET = 8'd200;

  // decode modes
  localparam logic [MODE_W-1:0] MODE_QUAD   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LEVELS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PDIR   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DUAL   = 3'd3;

  // pin pair bits
  localparam logic [1:0] PIN_FIRST  = 2'b01;
  localparam logic [1:0] PIN_SECOND = 2'b10;

  // quadrature step codes
  localparam logic [1:0] STEP_RIGHT = 2'd1;
  localparam logic [1:0] STEP_JUMP  = 2'd2;
  localparam logic [1:0] STEP_LEFT  = 2'd3;

  typedef struct packed {
    logic [PIN_W-1:0] first_pins;
    logic [PIN_W-1:0] second_pins;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic               direction;
    logic [SPEED_W-1:0] speed;
    logic               last;
  } out_beat_t;

  // what one lane found on a tick
  typedef struct packed {
    logic               changed;
    logic               direction;
    logic [SPEED_W-1:0] speed;
  } lane_rep_t;

  // position of a pin pair on the gray cycle 0,2,3,1
  function automatic logic [1:0] gray_pos(input logic [1:0] p);
    logic [1:0] r;
    case (p)
      2'd0:    r = 2'd0;
      2'd1:    r = 2'd3;
      2'd2:    r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

[src/rmid_lane.sv]
// ----------------------------------------------------------------------------
// rmid_lane
// One channel: decodes its pin pair in the selected mode and keeps the
// speed, direction, tick counter and previous pins of that channel
// ----------------------------------------------------------------------------
module rmid_lane
  import rmid_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic               step_i,
  input  logic               enable_i,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [SPEED_W-1:0] timeout_i,
  input  logic [1:0]         pins_i,
  output lane_rep_t          rep_o
);

  logic [1:0]         prev_q, prev_d;
  logic [SPEED_W-1:0] ticks_q, ticks_d;
  logic [SPEED_W-1:0] speed_q, speed_d;
  logic               dir_q, dir_d;
  logic [SPEED_W-1:0] edge_speed;
  logic [1:0]         step;
  logic [1:0]         pin_diff;

  // decode and counter update
  always_comb begin
    speed_d    = speed_q;
    dir_d      = dir_q;
    ticks_d    = ticks_q;
    prev_d     = pins_i;
    edge_speed = (ticks_q > timeout_i) ? '0 : timeout_i - ticks_q;
    step       = gray_pos(pins_i) - gray_pos(prev_q);
    pin_diff   = prev_q ^ pins_i;

    case (mode_i)
      MODE_QUAD: begin
        if (step == STEP_RIGHT) begin
          speed_d = edge_speed;
          dir_d   = 1'b1;
          ticks_d = '0;
        end else if (step == STEP_LEFT) begin
          speed_d = edge_speed;
          dir_d   = 1'b0;
          ticks_d = '0;
        end else if (step == STEP_JUMP) begin
          ticks_d = '0;
        end
      end
      MODE_LEVELS: begin
        if ((pins_i & PIN_FIRST) != 2'b00) begin
          dir_d = 1'b0;
        end else if ((pins_i & PIN_SECOND) != 2'b00) begin
          dir_d = 1'b1;
        end
        speed_d = SPEED_W'(1);
        ticks_d = '0;
      end
      MODE_PDIR: begin
        if ((pin_diff & PIN_FIRST) != 2'b00) begin
          speed_d = edge_speed;
          dir_d   = pins_i[1];
          ticks_d = '0;
        end
      end
      MODE_DUAL: begin
        if ((pin_diff & PIN_FIRST) != 2'b00) begin
          speed_d = edge_speed;
          dir_d   = 1'b0;
          ticks_d = '0;
        end else if ((pin_diff & PIN_SECOND) != 2'b00) begin
          speed_d = edge_speed;
          dir_d   = 1'b1;
          ticks_d = '0;
        end
      end
      default: begin
      end
    endcase

    // saturating tick counter, speed drops at timeout
    if (ticks_d >= timeout_i) begin
      speed_d = '0;
    end else begin
      ticks_d = ticks_d + SPEED_W'(1);
    end
  end

  // report of this tick
  always_comb begin
    rep_o.changed   = enable_i && ((speed_d != speed_q) || (dir_d != dir_q));
    rep_o.direction = dir_d;
    rep_o.speed     = speed_d;
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      ticks_q <= '0;
      speed_q <= '0;
      dir_q   <= 1'b0;
    end else if (clear_i) begin
      prev_q  <= '0;
      ticks_q <= '0;
      speed_q <= '0;
      dir_q   <= 1'b0;
    end else if (step_i && enable_i) begin
      prev_q  <= prev_d;
      ticks_q <= ticks_d;
      speed_q <= speed_d;
      dir_q   <= dir_d;
    end
  end

endmodule

[src/rmid_merge.sv]
// ----------------------------------------------------------------------------
// rmid_merge
// Collects the lane reports of a tick and sends them out through an output
// register in ascending channel order, one beat per cycle while not stalled
// ----------------------------------------------------------------------------
`include "multi_mode_rotary_input_decoder_assert.svh"

module rmid_merge
  import rmid_pkg::*;
#(
  parameter int unsigned CHANNELS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  lane_rep_t rep_i [CHANNELS],
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic [CHANNELS-1:0] pend_q, pend_d;
  logic [CHANNELS-1:0] sel_mask;
  logic [CHANNELS-1:0] pend_rest;
  logic                dir_q [CHANNELS];
  logic [SPEED_W-1:0]  speed_q [CHANNELS];
  logic [CH_W-1:0]     sel_ch;
  logic                sel_dir;
  logic [SPEED_W-1:0]  sel_speed;
  logic                load_out;
  logic                out_valid_q;
  out_beat_t           out_q;

  // lowest pending channel
  always_comb begin
    sel_mask  = '0;
    sel_ch    = '0;
    sel_dir   = 1'b0;
    sel_speed = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel_mask    = '0;
        sel_mask[i] = 1'b1;
        sel_ch      = CH_W'(i);
        sel_dir     = dir_q[i];
        sel_speed   = speed_q[i];
      end
    end
  end

  assign load_out  = (|pend_q) && (!out_valid_q || !out_stall_i);
  assign pend_rest = load_out ? (pend_q & ~sel_mask) : pend_q;
  assign free_o    = (pend_rest == '0);

  always_comb begin
    pend_d = pend_rest;
    if (load_i) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pend_d[i] = rep_i[i].changed;
      end
    end
  end

  // pending flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // report data per lane
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < CHANNELS; i++) begin
        dir_q[i]   <= rep_i[i].direction;
        speed_q[i] <= rep_i[i].speed;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.channel   <= sel_ch;
      out_q.direction <= sel_dir;
      out_q.speed     <= sel_speed;
      out_q.last      <= (pend_rest == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // a beat that is not last always has more reports behind it
  `RMID_ASSERT(a_more_behind, (out_valid_q && !out_q.last) |-> (|pend_q))
  // a pending report never waits behind an empty output register
  `RMID_ASSERT(a_no_bubble, ((|pend_q) && !out_valid_q) |=> out_valid_q)
  // reports of one tick leave in rising channel order
  `RMID_ASSERT_MSG(a_ch_order,
    (out_valid_q && !out_stall_i && !out_q.last) |=>
    (out_valid_q && (out_q.channel > $past(out_q.channel))),
    "rmid reports out of channel order")

endmodule

[src/multi_mode_rotary_input_decoder.sv]
// Flow: a tick accepted at an edge has its reports held in the pending flags;
//   the first moves into the output register once that register is free.
// Throughput: one report beat per cycle while the output is not stalled; a
//   tick holds the result channel until its last report moves into the output
//   register, and the next tick is taken in that same cycle.
// Reset: registers to defaults (timeout 200) and all channel state cleared.
// ----------------------------------------------------------------------------
// multi_mode_rotary_input_decoder
// Four-mode rotary and pulse input decoder with speed measurement: one lane
// per channel, merged into an ordered stream of change reports
// ----------------------------------------------------------------------------
module multi_mode_rotary_input_decoder
  import rmid_pkg::*;
#(
  parameter int unsigned CHANNELS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_beat_t          in_beat_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_beat_t         out_beat_o
);

  logic [PIN_W-1:0]         enable_q;
  logic [PIN_W*MODE_W-1:0]  modes_q;
  logic [SPEED_W-1:0]       timeout_q;
  logic                     cfg_hit;
  logic                     in_fire;
  logic                     merge_free;
  lane_rep_t                rep [CHANNELS];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= '0;
      modes_q   <= '0;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE:  enable_q  <= cfg_wdata_i[PIN_W-1:0];
        REG_MODES:   modes_q   <= cfg_wdata_i[PIN_W*MODE_W-1:0];
        REG_TIMEOUT: timeout_q <= cfg_wdata_i[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // any known register write clears the channels
  assign cfg_hit = cfg_we_i && ((cfg_idx_i == REG_ENABLE) || (cfg_idx_i == REG_MODES) ||
                                (cfg_idx_i == REG_TIMEOUT));

  assign in_stall_o = !merge_free;
  assign in_fire    = in_valid_i && merge_free;

  // channel lanes
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    logic              lane_en;
    logic [MODE_W-1:0] lane_mode;
    logic [1:0]        lane_pins;

    if (g < PIN_W) begin : g_wired
      assign lane_en   = enable_q[g];
      assign lane_mode = modes_q[g*MODE_W +: MODE_W];
      assign lane_pins = {in_beat_i.second_pins[g], in_beat_i.first_pins[g]};
    end else begin : g_unwired
      assign lane_en   = 1'b0;
      assign lane_mode = '0;
      assign lane_pins = '0;
    end

    rmid_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clear_i   (cfg_hit),
      .step_i    (in_fire),
      .enable_i  (lane_en),
      .mode_i    (lane_mode),
      .timeout_i (timeout_q),
      .pins_i    (lane_pins),
      .rep_o     (rep[g])
    );
  end

  // ordered report output
  rmid_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .rep_i       (rep),
    .free_o      (merge_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
